>>> src/pba_pkg.sv
// Shared constants and codes for the page bitmap allocator.
// Standalone package; used by the top level and the map RAM.
package pba_pkg;

	localparam int CNT_W       = 19;
	localparam int PAGE_SHIFT  = 12;
	localparam int ADDR_W      = 30;
	localparam int USED_W      = 31;
	localparam int FREE_ADDR_W = 32;
	localparam int OPCODE_W    = 2;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 1;

	localparam int MAX_PAGES_DEF     = 262144;
	localparam int MAP_WORD_BITS_DEF = 64;

	localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 19'd16384;
	localparam logic [CNT_W-1:0] RESERVED_RST   = 19'd1;

	localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_INIT  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OOM     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 1'd1;

endpackage

>>> src/page_bitmap_allocator_top.sv
// First-fit page-frame allocator: top level, command sequencer and result register.
// Depends on pba_pkg and pba_map_ram.
//
// One command at a time. The used-bit map sits in a RAM of MAP_WORDS words
// (MAX_PAGES / MAP_WORD_BITS rounded up) with a registered read, and each
// walk over that RAM covers one word per cycle: allocate reads words up to the
// first word with a clear bit, and reports out of memory when no page below the
// limit is free; free walks to the word holding the page and clears its bit if
// set, or is answered without a walk when the page is out of range; an unused
// opcode is answered without a walk; init rewrites every word.
// After reset the block clears every word of the RAM and holds
// in_stall high during that time; configuration writes are taken throughout.
// A finished result waits in the output register while the next command is
// already accepted.
module page_bitmap_allocator_top import pba_pkg::*; #(
	parameter int MAX_PAGES     = MAX_PAGES_DEF,
	parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [OPCODE_W-1:0]    opcode,
	input  logic [FREE_ADDR_W-1:0] free_address,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [ADDR_W-1:0]      page_address,
	output logic [STATUS_W-1:0]    status,
	output logic [USED_W-1:0]      used_bytes,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CNT_W-1:0]       cfg_data
);

	localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WC_W      = $clog2(MAP_WORDS + 1);
	localparam int BW        = $clog2(MAP_WORD_BITS);
	localparam int LIM_W     = $clog2(MAX_PAGES + 1);
	localparam int BASE_W    = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
	localparam int FPAGE_W   = FREE_ADDR_W - PAGE_SHIFT;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SWEEP = 6'b000010,
		S_SCAN  = 6'b000100,
		S_FWALK = 6'b001000,
		S_FREAD = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        page_count_q;
	logic [CNT_W-1:0]        reserved_count_q;
	logic [CNT_W-1:0]        used_count_q;
	logic [LIM_W-1:0]        limit_q;
	logic [LIM_W-1:0]        res_q;
	logic                    sweep_init_q;
	logic [FPAGE_W-1:0]      page_q;
	logic [WC_W-1:0]         wcnt_q;
	logic [BASE_W-1:0]       base_q;
	logic [BW-1:0]           fbit_q;
	logic [ADDR_W-1:0]       res_addr_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic                    out_valid_q;

	logic                    vld_s1;
	logic                    oob_s1;
	logic [AW-1:0]           w_s1;
	logic [BASE_W-1:0]       base_s1;

	logic                    in_accept;
	logic                    out_load;
	logic [LIM_W-1:0]        limit_c;
	logic [LIM_W-1:0]        res_c;
	logic                    iss_oob;
	logic                    last_word;
	logic [FPAGE_W-1:0]      in_page;
	logic                    free_hit;
	logic [BW:0]             fill_len;
	logic [31:0]             fill_diff;
	logic [MAP_WORD_BITS-1:0] sweep_word;
	logic [MAP_WORD_BITS-1:0] free_bits;
	logic [BW-1:0]           hit_bit;
	logic [BASE_W-1:0]       hit_page;
	logic [BASE_W+PAGE_SHIFT-1:0] hit_addr_wide;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [MAP_WORD_BITS-1:0] ram_wdata;
	logic [MAP_WORD_BITS-1:0] rd_data;

	pba_map_ram #(
		.DEPTH(MAP_WORDS),
		.WIDTH(MAP_WORD_BITS),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(wcnt_q[AW-1:0]),
		.rdata(rd_data)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	always_comb begin
		limit_c = (32'(page_count_q) > 32'(MAX_PAGES)) ? LIM_W'(MAX_PAGES)
			: LIM_W'(page_count_q);
		res_c = (32'(reserved_count_q) > 32'(limit_c)) ? limit_c
			: LIM_W'(reserved_count_q);
	end

	assign in_page   = free_address[FREE_ADDR_W-1:PAGE_SHIFT];
	assign last_word = (wcnt_q == WC_W'(MAP_WORDS - 1));
	assign iss_oob   = (32'(base_q) >= 32'(limit_q)) || (wcnt_q == WC_W'(MAP_WORDS));
	assign free_hit  = (32'(page_q) < 32'(base_q) + 32'(MAP_WORD_BITS));

	// Init pattern for the word at base_q: low (res - base) bits set, saturated.
	always_comb begin
		fill_diff = 32'(res_q) - 32'(base_q);
		if (32'(res_q) <= 32'(base_q)) begin
			fill_len = '0;
		end else if (fill_diff >= 32'(MAP_WORD_BITS)) begin
			fill_len = (BW+1)'(MAP_WORD_BITS);
		end else begin
			fill_len = (BW+1)'(fill_diff);
		end
		for (int j = 0; j < MAP_WORD_BITS; j++) begin
			sweep_word[j] = ((BW+1)'(j) < fill_len);
		end
	end

	// lowest clear bit of the word returned by the scan
	always_comb begin
		free_bits = ~rd_data;
		hit_bit   = '0;
		for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
			if (free_bits[j]) begin
				hit_bit = BW'(j);
			end
		end
		hit_page      = base_s1 + BASE_W'(hit_bit);
		hit_addr_wide = {hit_page, {PAGE_SHIFT{1'b0}}};
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_s1;
		ram_wdata = rd_data;
		unique case (state_q)
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = wcnt_q[AW-1:0];
				ram_wdata = sweep_word;
			end
			S_SCAN: begin
				if (vld_s1 && !oob_s1 && (|free_bits)
					&& (32'(hit_page) < 32'(limit_q))) begin
					ram_we    = 1'b1;
					ram_wdata = rd_data | (MAP_WORD_BITS'(1) << hit_bit);
				end
			end
			S_FREAD: begin
				if (rd_data[fbit_q]) begin
					ram_we    = 1'b1;
					ram_wdata = rd_data & ~(MAP_WORD_BITS'(1) << fbit_q);
				end
			end
			S_IDLE, S_FWALK, S_RESP: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q     <= PAGE_COUNT_RST;
			reserved_count_q <= RESERVED_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PAGE_COUNT: page_count_q     <= cfg_data;
				CFG_RESERVED:   reserved_count_q <= cfg_data;
				default:        page_count_q     <= page_count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_init_q <= 1'b0;
			res_q        <= '0;
			limit_q      <= '0;
			wcnt_q       <= '0;
			base_q       <= '0;
			used_count_q <= '0;
			vld_s1       <= 1'b0;
			oob_s1       <= 1'b0;
			w_s1         <= '0;
			base_s1      <= '0;
			fbit_q       <= '0;
			res_addr_q   <= '0;
			res_status_q <= STAT_DONE;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						wcnt_q  <= '0;
						base_q  <= '0;
						vld_s1  <= 1'b0;
						limit_q <= limit_c;
						unique case (opcode)
							OP_ALLOC: begin
								state_q <= S_SCAN;
							end
							OP_FREE: begin
								if (32'(in_page) < 32'(limit_c)) begin
									state_q <= S_FWALK;
								end else begin
									res_status_q <= STAT_IGNORED;
									res_addr_q   <= '0;
									state_q      <= S_RESP;
								end
							end
							OP_INIT: begin
								res_q        <= res_c;
								used_count_q <= CNT_W'(res_c);
								sweep_init_q <= 1'b1;
								state_q      <= S_SWEEP;
							end
							OP_NONE: begin
								res_status_q <= STAT_DONE;
								res_addr_q   <= '0;
								state_q      <= S_RESP;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SWEEP: begin
					wcnt_q <= wcnt_q + WC_W'(1);
					base_q <= base_q + BASE_W'(MAP_WORD_BITS);
					if (last_word) begin
						res_status_q <= STAT_DONE;
						res_addr_q   <= '0;
						state_q      <= sweep_init_q ? S_RESP : S_IDLE;
					end
				end
				S_SCAN: begin
					// read of word wcnt_q issued every cycle, checked in the cycle after
					vld_s1  <= 1'b1;
					oob_s1  <= iss_oob;
					w_s1    <= wcnt_q[AW-1:0];
					base_s1 <= base_q;
					if (!iss_oob) begin
						wcnt_q <= wcnt_q + WC_W'(1);
						base_q <= base_q + BASE_W'(MAP_WORD_BITS);
					end
					if (vld_s1) begin
						if (oob_s1) begin
							res_status_q <= STAT_OOM;
							res_addr_q   <= '0;
							state_q      <= S_RESP;
						end else if (|free_bits) begin
							if (32'(hit_page) >= 32'(limit_q)) begin
								res_status_q <= STAT_OOM;
								res_addr_q   <= '0;
							end else begin
								res_status_q <= STAT_DONE;
								res_addr_q   <= ADDR_W'(hit_addr_wide);
								used_count_q <= used_count_q + CNT_W'(1);
							end
							state_q <= S_RESP;
						end
					end
				end
				S_FWALK: begin
					if (free_hit) begin
						w_s1    <= wcnt_q[AW-1:0];
						fbit_q  <= BW'(32'(page_q) - 32'(base_q));
						state_q <= S_FREAD;
					end else begin
						wcnt_q <= wcnt_q + WC_W'(1);
						base_q <= base_q + BASE_W'(MAP_WORD_BITS);
					end
				end
				S_FREAD: begin
					res_addr_q <= '0;
					if (rd_data[fbit_q]) begin
						res_status_q <= STAT_DONE;
						used_count_q <= used_count_q - CNT_W'(1);
					end else begin
						res_status_q <= STAT_IGNORED;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					vld_s1 <= 1'b0;
					if (out_load) begin
						sweep_init_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// free page number captured with the command
	always_ff @(posedge clk) begin
		if (in_accept) begin
			page_q <= in_page;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			page_address <= res_addr_q;
			status       <= res_status_q;
			used_bytes   <= USED_W'({used_count_q, {PAGE_SHIFT{1'b0}}});
		end
	end

	// used count tracks set bits, so it can never pass the map size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_count_q) <= 32'(MAX_PAGES))
		else $error("used page count above map size");

	// a word checked by the scan was only issued when it started below the limit
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && vld_s1 && !oob_s1) |-> (32'(base_s1) < 32'(limit_q)))
		else $error("scan checked a word past the page limit");

	// alloc and free write back the word read with exactly one bit flipped
	a_rmw_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != S_SWEEP) |-> $onehot(ram_wdata ^ rd_data))
		else $error("map update changed other than one bit");

	// a free read always follows the walk that located its word
	a_fread_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FREAD) |-> ($past(state_q) == S_FWALK))
		else $error("free read without word walk");

endmodule

>>> src/pba_map_ram.sv
// Used-bit map storage: simple dual-port RAM, one write and one registered read.
// Depends on pba_pkg only for its parameter defaults; no shared types needed.
module pba_map_ram import pba_pkg::*; #(
	parameter int DEPTH = MAX_PAGES_DEF / MAP_WORD_BITS_DEF,
	parameter int WIDTH = MAP_WORD_BITS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
